### sv/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes of the per-unit priority task scheduler: beat
// structs, command and status codes, state encoding and cell control.
// ----------------------------------------------------------------------------
package pts_pkg;

	// Unit kinds: cpu, fpu, gpu; a two-bit unit field can also name a fourth,
	// nonexistent unit.
	localparam int UNITS      = 3;
	localparam int UNIT_W     = 2;
	localparam int UNIT_SLOTS = 1 << UNIT_W;

	// Fixed field widths of the beats
	localparam int PRIO_W = 4;
	localparam int ID_W   = 16;

	// Parameter defaults
	localparam int DEF_QUEUE_DEPTH   = 16;
	localparam int DEF_ID_BITS       = 16;
	localparam int DEF_PRIORITY_BITS = 4;

	localparam logic CMD_INSERT   = 1'b0;
	localparam logic CMD_SCHEDULE = 1'b1;

	typedef enum logic [2:0] {
		STAT_INSERTED = 3'd0,
		STAT_DROPPED  = 3'd1,
		STAT_SERVED   = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_NONE     = 3'd4
	} pts_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INSERT,
		S_SERVE
	} pts_state_t;

	// Input beat
	typedef struct packed {
		logic                     cmd;
		logic [UNIT_W-1:0]        unit_kind;
		logic [PRIO_W-1:0]        task_priority;
		logic signed [ID_W-1:0]   task_id;
		logic [UNITS-1:0]         serve_mask;
	} pts_item_t;

	// Result beat
	typedef struct packed {
		pts_status_t              status;
		logic [UNIT_W-1:0]        served_unit;
		logic [PRIO_W-1:0]        served_priority;
		logic signed [ID_W-1:0]   served_id;
		logic                     last_result;
	} pts_result_t;

	// Per-queue cell control
	typedef struct packed {
		logic ins;
		logic pop;
	} pts_ctl_t;

endpackage

### sv/pts_cell.sv
// ----------------------------------------------------------------------------
// pts_cell
// One slot of a sorted queue. Holds a task and, on insert, keeps it, takes
// the new task or takes its upper neighbor's task; on pop, takes its lower
// neighbor's task. The chain stays sorted best first.
// ----------------------------------------------------------------------------
module pts_cell #(
	parameter int PRIORITY_BITS = 4,
	parameter int ID_BITS       = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pts_pkg::pts_ctl_t         ctl,
	input  logic [PRIORITY_BITS-1:0]  new_prio,
	input  logic signed [ID_BITS-1:0] new_id,
	input  logic                      prev_valid,
	input  logic [PRIORITY_BITS-1:0]  prev_prio,
	input  logic signed [ID_BITS-1:0] prev_id,
	input  logic                      prev_gt,
	input  logic                      next_valid,
	input  logic [PRIORITY_BITS-1:0]  next_prio,
	input  logic signed [ID_BITS-1:0] next_id,
	output logic                      valid,
	output logic [PRIORITY_BITS-1:0]  prio,
	output logic signed [ID_BITS-1:0] id,
	output logic                      gt
);
	import pts_pkg::*;

	logic                      valid_q;
	logic [PRIORITY_BITS-1:0]  prio_q;
	logic signed [ID_BITS-1:0] id_q;

	// New task goes ahead of this slot: slot empty, higher priority, or
	// same priority with a smaller id
	assign gt = !valid_q || (new_prio > prio_q) ||
		((new_prio == prio_q) && (new_id < id_q));

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			if (prev_gt) begin
				valid_q <= prev_valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end
	end

	// Shift or load the task payload
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_gt) begin
				prio_q <= prev_prio;
				id_q   <= prev_id;
			end else if (gt) begin
				prio_q <= new_prio;
				id_q   <= new_id;
			end
		end else if (ctl.pop) begin
			prio_q <= next_prio;
			id_q   <= next_id;
		end
	end

	assign valid = valid_q;
	assign prio  = prio_q;
	assign id    = id_q;

endmodule

### sv/pts_queue.sv
// ----------------------------------------------------------------------------
// pts_queue
// Bounded max-priority queue built as a chain of sorted cells. The head cell
// always holds the best task; full is the last cell being occupied.
// ----------------------------------------------------------------------------
module pts_queue #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 4,
	parameter int ID_BITS       = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pts_pkg::pts_ctl_t         ctl,
	input  logic [PRIORITY_BITS-1:0]  new_prio,
	input  logic signed [ID_BITS-1:0] new_id,
	output logic                      head_valid,
	output logic [PRIORITY_BITS-1:0]  head_prio,
	output logic signed [ID_BITS-1:0] head_id,
	output logic                      full
);
	import pts_pkg::*;

	// Chain links: entry k+1 is cell k, entries 0 and QUEUE_DEPTH+1 are the
	// empty boundaries above the head and below the tail
	logic                      c_valid [QUEUE_DEPTH+2];
	logic [PRIORITY_BITS-1:0]  c_prio  [QUEUE_DEPTH+2];
	logic signed [ID_BITS-1:0] c_id    [QUEUE_DEPTH+2];
	logic                      c_gt    [QUEUE_DEPTH+2];

	// Tie the boundaries
	assign c_valid[0]             = 1'b0;
	assign c_prio[0]              = '0;
	assign c_id[0]                = '0;
	assign c_gt[0]                = 1'b0;
	assign c_valid[QUEUE_DEPTH+1] = 1'b0;
	assign c_prio[QUEUE_DEPTH+1]  = '0;
	assign c_id[QUEUE_DEPTH+1]    = '0;
	assign c_gt[QUEUE_DEPTH+1]    = 1'b0;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		pts_cell #(
			.PRIORITY_BITS (PRIORITY_BITS),
			.ID_BITS       (ID_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_prio   (new_prio),
			.new_id     (new_id),
			.prev_valid (c_valid[k]),
			.prev_prio  (c_prio[k]),
			.prev_id    (c_id[k]),
			.prev_gt    (c_gt[k]),
			.next_valid (c_valid[k+2]),
			.next_prio  (c_prio[k+2]),
			.next_id    (c_id[k+2]),
			.valid      (c_valid[k+1]),
			.prio       (c_prio[k+1]),
			.id         (c_id[k+1]),
			.gt         (c_gt[k+1])
		);
	end

	assign head_valid = c_valid[1];
	assign head_prio  = c_prio[1];
	assign head_id    = c_id[1];
	assign full       = c_valid[QUEUE_DEPTH];

endmodule

### sv/per_unit_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// per_unit_priority_task_scheduler
// Three bounded max-priority task queues (cpu, fpu, gpu) with insert and
// masked schedule commands.
// ----------------------------------------------------------------------------
// Usage:
//   An item beat is taken at a rising edge with start high and busy low.
//   cmd selects insert (task joins the queue of unit_kind, or is dropped when
//   that queue is full or the unit does not exist) or schedule (for each set
//   bit of serve_mask, lowest first, pop and report the best task of that
//   unit, or report an empty queue; a zero mask gives one "nothing
//   requested" result).
//   Each result beat sits on result for one cycle with result_strobe high;
//   the receiver cannot stall it. last_result marks the final beat of an
//   item.
//   The accepting edge moves the state to S_INSERT or S_SERVE, and each
//   result beat is registered from that state; further results of a
//   schedule follow one per cycle.
//   The cell chain takes one insert or pop per queue per cycle, and busy
//   stays high until the last result beat of an item is registered, so no
//   new item is taken before then.
//   The next item may be taken while the last result beat is still shown.
//   Reset empties all queues and clears busy and result_strobe.
// ----------------------------------------------------------------------------
module per_unit_priority_task_scheduler #(
	parameter int QUEUE_DEPTH   = pts_pkg::DEF_QUEUE_DEPTH,
	parameter int ID_BITS       = pts_pkg::DEF_ID_BITS,
	parameter int PRIORITY_BITS = pts_pkg::DEF_PRIORITY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pts_pkg::pts_item_t   item,
	output pts_pkg::pts_result_t result,
	output logic                 result_strobe
);
	import pts_pkg::*;

	localparam int PW = (PRIORITY_BITS > PRIO_W) ? PRIORITY_BITS : PRIO_W;
	localparam int IW = (ID_BITS > ID_W) ? ID_BITS : ID_W;

	pts_state_t  state_q, state_d;
	pts_item_t   item_q;
	logic [UNITS-1:0] mask_q, mask_d;
	pts_result_t result_q, result_d;
	logic        strobe_q, strobe_d;
	logic        accept;

	pts_ctl_t                  ctl       [UNIT_SLOTS];
	logic                      q_valid   [UNIT_SLOTS];
	logic [PRIORITY_BITS-1:0]  q_prio    [UNIT_SLOTS];
	logic signed [ID_BITS-1:0] q_id      [UNIT_SLOTS];
	logic                      q_full    [UNIT_SLOTS];

	logic [PW-1:0]             prio_ext;
	logic signed [IW-1:0]      id_ext;
	logic [PRIORITY_BITS-1:0]  new_prio;
	logic signed [ID_BITS-1:0] new_id;

	logic [UNIT_W-1:0]         sel;
	logic [UNITS-1:0]          sel_bit;
	logic [PW-1:0]             head_prio_ext;
	logic [IW-1:0]             head_id_ext;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Fit the beat fields to the stored widths
	assign prio_ext = PW'(item_q.task_priority);
	assign id_ext   = IW'($signed(item_q.task_id));
	assign new_prio = prio_ext[PRIORITY_BITS-1:0];
	assign new_id   = id_ext[ID_BITS-1:0];

	// Queues, one per unit
	for (genvar u = 0; u < UNITS; u++) begin : g_queue
		pts_queue #(
			.QUEUE_DEPTH   (QUEUE_DEPTH),
			.PRIORITY_BITS (PRIORITY_BITS),
			.ID_BITS       (ID_BITS)
		) u_queue (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[u]),
			.new_prio   (new_prio),
			.new_id     (new_id),
			.head_valid (q_valid[u]),
			.head_prio  (q_prio[u]),
			.head_id    (q_id[u]),
			.full       (q_full[u])
		);
	end

	// The missing fourth unit reads as full and empty
	for (genvar u = UNITS; u < UNIT_SLOTS; u++) begin : g_none
		assign q_valid[u] = 1'b0;
		assign q_prio[u]  = '0;
		assign q_id[u]    = '0;
		assign q_full[u]  = 1'b1;
	end

	// Pick the lowest pending unit of the serve mask
	always_comb begin
		sel     = '0;
		sel_bit = '0;
		for (int u = UNITS - 1; u >= 0; u--) begin
			if (mask_q[u]) begin
				sel     = UNIT_W'(u);
				sel_bit = UNITS'(1) << u;
			end
		end
	end

	// Stored head fields back to beat widths
	assign head_prio_ext = PW'(q_prio[sel]);
	assign head_id_ext   = IW'(unsigned'(q_id[sel]));

	// Next state, cell control and next result beat
	always_comb begin
		state_d  = state_q;
		mask_d   = mask_q;
		strobe_d = 1'b0;
		result_d = result_q;
		for (int u = 0; u < UNIT_SLOTS; u++) begin
			ctl[u] = '0;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (item.cmd == CMD_INSERT) ? S_INSERT : S_SERVE;
					mask_d  = item.serve_mask;
				end
			end
			S_INSERT: begin
				strobe_d                 = 1'b1;
				result_d.served_unit     = item_q.unit_kind;
				result_d.served_priority = '0;
				result_d.served_id       = '0;
				result_d.last_result     = 1'b1;
				if (q_full[item_q.unit_kind]) begin
					result_d.status = STAT_DROPPED;
				end else begin
					result_d.status           = STAT_INSERTED;
					ctl[item_q.unit_kind].ins = 1'b1;
				end
				state_d = S_IDLE;
			end
			S_SERVE: begin
				strobe_d = 1'b1;
				if (mask_q == '0) begin
					result_d.status          = STAT_NONE;
					result_d.served_unit     = '0;
					result_d.served_priority = '0;
					result_d.served_id       = '0;
					result_d.last_result     = 1'b1;
					state_d                  = S_IDLE;
				end else begin
					mask_d               = mask_q & ~sel_bit;
					result_d.served_unit = sel;
					result_d.last_result = (mask_d == '0);
					if (q_valid[sel]) begin
						result_d.status          = STAT_SERVED;
						result_d.served_priority = head_prio_ext[PRIO_W-1:0];
						result_d.served_id       = head_id_ext[ID_W-1:0];
						ctl[sel].pop             = 1'b1;
					end else begin
						result_d.status          = STAT_EMPTY;
						result_d.served_priority = '0;
						result_d.served_id       = '0;
					end
					if (mask_d == '0) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	// Hold the accepted beat, remaining mask and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		mask_q   <= mask_d;
		result_q <= result_d;
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

### sv/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the scheduler: result sequencing and field rules.
// ----------------------------------------------------------------------------
module pts_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input pts_pkg::pts_item_t   item,
	input pts_pkg::pts_result_t result,
	input logic                 result_strobe
);
	import pts_pkg::*;

	// An accepted beat is always answered by a result beat
	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 result_strobe)
		else $error("no result after accepted beat");

	// A result that is not the last one is followed by another
	a_more_results: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last_result |=> result_strobe)
		else $error("result sequence broken");

	// Single-result outcomes always close the item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.status == STAT_INSERTED ||
			result.status == STAT_DROPPED || result.status == STAT_NONE)
		|-> result.last_result)
		else $error("single-result outcome without last flag");

	// Only a served task carries priority and id
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status != STAT_SERVED
		|-> result.served_priority == '0 && result.served_id == '0)
		else $error("payload on result without served task");

	// While a non-final result shows, no new beat is taken
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last_result |-> busy)
		else $error("idle in the middle of a result sequence");

endmodule

bind per_unit_priority_task_scheduler pts_checker u_pts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.item          (item),
	.result        (result),
	.result_strobe (result_strobe)
);

### tb/sv/per_unit_priority_task_scheduler_test.sv
// ----------------------------------------------------------------------------
// per_unit_priority_task_scheduler_test
// Self-checking bench for the per-unit task scheduler. It drives insert and
// schedule command beats with random gaps and keeps its own copy of the three
// task queues. Every result beat is compared field by field with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module per_unit_priority_task_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pts_pkg::*;

	localparam int DEPTH       = DEF_QUEUE_DEPTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 6;
	localparam int PHASE_BEATS = 32;

	typedef struct {
		pts_item_t   beat;
		bit          drain;
		int unsigned gap;
	} queued_beat_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	pts_item_t   item;
	pts_result_t result;
	logic        result_strobe;

	per_unit_priority_task_scheduler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result        (result),
		.result_strobe (result_strobe)
	);

	// Shadow copy of the task queues
	logic                   slot_valid [UNITS][DEPTH];
	logic [PRIO_W-1:0]      slot_prio  [UNITS][DEPTH];
	logic signed [ID_W-1:0] slot_id    [UNITS][DEPTH];
	int unsigned            queue_fill [UNITS];

	queued_beat_t beat_q[$];
	pts_result_t  due_results[$];
	int unsigned  gap_left;
	bit           beat_taken;
	int unsigned  n_errors;
	int unsigned  cycle_count;

	// Clock: 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic pts_result_t make_result(pts_status_t st, logic [UNIT_W-1:0] unit,
			logic [PRIO_W-1:0] prio, logic signed [ID_W-1:0] id, logic last);
		pts_result_t r;
		r.status          = st;
		r.served_unit     = unit;
		r.served_priority = prio;
		r.served_id       = id;
		r.last_result     = last;
		return r;
	endfunction

	// Append one predicted result beat
	function automatic void note_result(pts_result_t r);
		due_results = {due_results, r};
	endfunction

	// Update the shadow queues with one accepted beat and queue its results
	task automatic apply_to_task_queues(input pts_item_t it);
		int u;
		int i;
		int best;
		logic last;
		if (it.cmd == CMD_INSERT) begin
			if (it.unit_kind >= UNITS || queue_fill[it.unit_kind] >= DEPTH) begin
				note_result(make_result(STAT_DROPPED, it.unit_kind, '0, '0, 1'b1));
			end else begin
				u = it.unit_kind;
				for (i = 0; i < DEPTH; i++) begin
					if (!slot_valid[u][i]) begin
						slot_valid[u][i] = 1'b1;
						slot_prio[u][i]  = it.task_priority;
						slot_id[u][i]    = it.task_id;
						break;
					end
				end
				queue_fill[u]++;
				note_result(make_result(STAT_INSERTED, it.unit_kind, '0, '0, 1'b1));
			end
		end else if (it.serve_mask == '0) begin
			note_result(make_result(STAT_NONE, '0, '0, '0, 1'b1));
		end else begin
			for (u = 0; u < UNITS; u++) begin
				if (it.serve_mask[u]) begin
					last = ((it.serve_mask >> (u + 1)) == '0);
					best = -1;
					// highest priority, then smallest id, then lowest slot
					for (i = 0; i < DEPTH; i++) begin
						if (slot_valid[u][i] && (best < 0 ||
								slot_prio[u][i] > slot_prio[u][best] ||
								(slot_prio[u][i] == slot_prio[u][best] &&
								slot_id[u][i] < slot_id[u][best])))
							best = i;
					end
					if (best < 0) begin
						note_result(make_result(STAT_EMPTY, u[UNIT_W-1:0], '0, '0, last));
					end else begin
						note_result(make_result(STAT_SERVED, u[UNIT_W-1:0],
							slot_prio[u][best], slot_id[u][best], last));
						slot_valid[u][best] = 1'b0;
						queue_fill[u]--;
					end
				end
			end
		end
	endtask

	function automatic string result_text(pts_result_t r);
		return $sformatf("status=%0d unit=%0d prio=%0d id=%0d last=%0d", r.status,
			r.served_unit, r.served_priority, r.served_id, r.last_result);
	endfunction

	// Monitor: check result beats, then record the beat taken at this edge
	always @(posedge clk) begin
		pts_result_t want;
		if (arst_n && result_strobe) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result beat: %s", $time, result_text(result));
				n_errors++;
			end else begin
				want = due_results.pop_front();
				if (result.status !== want.status || result.served_unit !== want.served_unit ||
						result.served_priority !== want.served_priority ||
						result.served_id !== want.served_id ||
						result.last_result !== want.last_result) begin
					$display("%0t: result mismatch: expected %s, actual %s", $time,
						result_text(want), result_text(result));
					n_errors++;
				end
			end
		end
		beat_taken = arst_n && start && !busy;
		if (beat_taken)
			apply_to_task_queues(item);
	end

	// Driver: hold a beat until taken, idle for its gap, stop at drain marks
	always @(negedge clk) begin
		if (arst_n && !(start && !beat_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (beat_q.size() > 0 && beat_q[0].drain) begin
				start <= 1'b0;
				if (due_results.size() == 0)
					void'(beat_q.pop_front());
			end else if (beat_q.size() > 0) begin
				item     <= beat_q[0].beat;
				gap_left <= beat_q[0].gap;
				start    <= 1'b1;
				void'(beat_q.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Guard against a hang
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** per_unit_priority_task_scheduler: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned random_gap(bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic add_insert(input logic [UNIT_W-1:0] unit, input int prio, input int id,
			input int unsigned gap);
		queued_beat_t q;
		logic [63:0]  rnd;
		rnd                  = {$urandom, $urandom};
		q.beat               = rnd[$bits(pts_item_t)-1:0];
		q.beat.cmd           = CMD_INSERT;
		q.beat.unit_kind     = unit;
		q.beat.task_priority = prio[PRIO_W-1:0];
		q.beat.task_id       = id[ID_W-1:0];
		q.drain              = 1'b0;
		q.gap                = gap;
		beat_q               = {beat_q, q};
	endtask

	task automatic add_schedule(input logic [UNITS-1:0] mask, input int unsigned gap);
		queued_beat_t q;
		logic [63:0]  rnd;
		// unit, priority and id carry junk on a schedule beat
		rnd               = {$urandom, $urandom};
		q.beat            = rnd[$bits(pts_item_t)-1:0];
		q.beat.cmd        = CMD_SCHEDULE;
		q.beat.serve_mask = mask;
		q.drain           = 1'b0;
		q.gap             = gap;
		beat_q            = {beat_q, q};
	endtask

	task automatic add_drain();
		queued_beat_t q;
		q.beat  = '0;
		q.drain = 1'b1;
		q.gap   = 0;
		beat_q  = {beat_q, q};
	endtask

	initial begin
		bit          fill;
		bit          burst;
		int unsigned fav;
		int unsigned r;
		int unsigned unit;
		int          prio;
		int          id;
		for (int u = 0; u < UNITS; u++) begin
			queue_fill[u] = 0;
			for (int i = 0; i < DEPTH; i++)
				slot_valid[u][i] = 1'b0;
		end
		n_errors    = 0;
		cycle_count = 0;
		beat_taken  = 1'b0;
		gap_left    = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;

		// Directed: empty queues, zero mask, missing unit, extremes and ties
		add_schedule(3'b111, 0);
		add_schedule(3'b000, 1);
		add_insert(2'd3, 9, 123, 0);
		add_insert(2'd0, 15, 32767, 0);
		add_insert(2'd0, 15, -32768, 2);
		add_insert(2'd0, 0, 0, 0);
		add_insert(2'd1, 7, 5, 0);
		add_insert(2'd1, 7, 5, 0);
		add_insert(2'd2, 0, -1, 5);
		add_insert(2'd2, 15, 0, 0);
		add_drain();
		add_schedule(3'b001, 0);
		add_schedule(3'b110, 0);
		add_schedule(3'b101, 3);
		add_schedule(3'b010, 0);
		add_schedule(3'b011, 0);
		add_schedule(3'b100, 1);
		add_schedule(3'b111, 0);
		add_drain();

		// Random: alternate filling and draining phases around a favored unit
		for (int p = 0; p < PHASES; p++) begin
			fill  = (p % 2 == 0);
			burst = (p == 2);
			fav   = $urandom_range(0, 2);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if ($urandom_range(0, 99) < (fill ? 88 : 30)) begin
					r    = $urandom_range(0, 99);
					unit = (r < 6) ? 3 : (r < 70) ? fav : $urandom_range(0, 2);
					prio = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
					id   = $urandom_range(0, 1) ? int'($urandom_range(0, 8)) - 4 : int'($urandom);
					add_insert(unit[UNIT_W-1:0], prio, id, random_gap(burst));
				end else begin
					add_schedule(UNITS'($urandom_range(0, 7)), random_gap(burst));
				end
			end
			if (p == 2 || p == 3)
				add_drain();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Let everything drain, then allow the pipeline to settle
		while (beat_q.size() > 0 || start || due_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (due_results.size() > 0) begin
			$display("%0t: %0d expected results never arrived", $time, due_results.size());
			n_errors++;
		end

		if (n_errors == 0) begin
			$display("** per_unit_priority_task_scheduler: PASSED **");
		end else begin
			$display("** per_unit_priority_task_scheduler: FAILED **");
		end
		$finish;
	end

endmodule

### sim.f
sv/pts_pkg.sv
sv/pts_cell.sv
sv/pts_queue.sv
sv/per_unit_priority_task_scheduler.sv
sv/pts_checker.sv
tb/sv/per_unit_priority_task_scheduler_test.sv
